>>> hw/rtl/dbgu_pkg.sv
package dbgu_pkg;

    localparam int DEF_STACK_DEPTH = 2048;

    localparam int COUNT_W = 12;
    localparam int PCT_W   = 15;
    localparam int PROD_W  = COUNT_W + PCT_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
    localparam logic [PCT_W-1:0]   PERCENT_SCALE = PCT_W'(25600);

    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_G_UC  = 8'h47;
    localparam logic [7:0] CHAR_G_LC  = 8'h67;
    localparam logic [7:0] CHAR_U_UC  = 8'h55;
    localparam logic [7:0] CHAR_U_LC  = 8'h75;
    localparam logic [7:0] CHAR_T_UC  = 8'h54;
    localparam logic [7:0] CHAR_T_LC  = 8'h74;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_G     = 2'd1,
        CLS_UT    = 2'd2
    } class_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNMATCHED = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed {
        logic               start;
        logic [COUNT_W-1:0] gu;
        logic [COUNT_W-1:0] pairs;
    } div_req_t;

    function automatic class_t base_class(input logic [7:0] c);
        class_t cls;
        cls = CLS_OTHER;
        if (c == CHAR_G_UC || c == CHAR_G_LC)
        begin
            cls = CLS_G;
        end
        else if (c == CHAR_U_UC || c == CHAR_U_LC || c == CHAR_T_UC || c == CHAR_T_LC)
        begin
            cls = CLS_UT;
        end
        return cls;
    endfunction

endpackage

>>> hw/rtl/dbgu_ram.sv
module dbgu_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = dbgu_pkg::DEF_STACK_DEPTH,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/dbgu_div.sv
module dbgu_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dbgu_pkg::div_req_t                req,
    input  logic                              ack,
    output logic                              done,
    output logic [dbgu_pkg::PCT_W-1:0]        quotient
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } div_state_t;

    localparam int CW = $clog2(dbgu_pkg::PCT_W);
    localparam logic [CW-1:0] LAST_STEP = CW'(dbgu_pkg::PCT_W - 1);

    div_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic [dbgu_pkg::COUNT_W-1:0] gu_reg;
    logic [dbgu_pkg::COUNT_W-1:0] pairs_reg;
    logic [dbgu_pkg::COUNT_W-1:0] rem_reg;
    logic [dbgu_pkg::PCT_W-1:0]   quo_reg;

    logic [dbgu_pkg::PROD_W-1:0]  prod;
    logic [dbgu_pkg::COUNT_W:0]   trial;
    logic [dbgu_pkg::COUNT_W:0]   diff;
    logic                         ge;

    assign prod  = dbgu_pkg::PROD_W'(gu_reg) * dbgu_pkg::PROD_W'(dbgu_pkg::PERCENT_SCALE);
    assign trial = {rem_reg, quo_reg[dbgu_pkg::PCT_W-1]};
    assign ge    = trial >= {1'b0, pairs_reg};
    assign diff  = trial - {1'b0, pairs_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (req.start) state_next = S_MUL;
            S_MUL:   state_next = S_DIV;
            S_DIV:   if (cnt_reg == LAST_STEP) state_next = S_DONE;
            S_DONE:  if (ack) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_MUL)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == S_DIV)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // restoring division, one quotient bit per cycle; the product's upper
    // bits already sit below the divisor because the quotient fits PCT_W
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    gu_reg    <= req.gu;
                    pairs_reg <= req.pairs;
                end
            end
            S_MUL:
            begin
                rem_reg <= prod[dbgu_pkg::PROD_W-1:dbgu_pkg::PCT_W];
                quo_reg <= prod[dbgu_pkg::PCT_W-1:0];
            end
            S_DIV:
            begin
                rem_reg <= ge ? diff[dbgu_pkg::COUNT_W-1:0] : trial[dbgu_pkg::COUNT_W-1:0];
                quo_reg <= {quo_reg[dbgu_pkg::PCT_W-2:0], ge};
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign done     = (state_reg == S_DONE);
    assign quotient = (pairs_reg == '0) ? '0 : quo_reg;

endmodule

>>> hw/rtl/dot_bracket_gu_pair_counter.sv
// GU base-pair share of a dot-bracket structure.
//
// Input channel (in_valid/in_ready): one sequence position per transfer,
// seq_char, struct_char and last. '(' pushes the base class onto a stack held
// in a single-port RAM of STACK_DEPTH entries, ')' pops it and counts the pair in
// the cycle after. Positions stream at one per cycle while in_ready is high.
// Output channel (out_valid/out_ready): one result per sequence, after the
// transfer with last set: gu_percent, gu_pairs, all_pairs and status.
// From the last transfer the result passes the stack read, the multiply and the
// bit-serial divider before it reaches the output register. in_ready stays low
// from the last transfer until the result is loaded into the output register.
// The output register lets the next sequence stream in while a result waits;
// a stalled receiver only holds off the next result.
// Reset clears the stack level, counters, status and all valid flags; the
// stack RAM is not cleared since only written entries are read.
module dot_bracket_gu_pair_counter #(
    parameter int STACK_DEPTH = dbgu_pkg::DEF_STACK_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  seq_char,
    input  logic [7:0]  struct_char,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [14:0] gu_percent,
    output logic [11:0] gu_pairs,
    output logic [11:0] all_pairs,
    output logic [1:0]  status
);

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH);

    logic                      accept;
    logic                      is_open;
    logic                      is_close;
    logic                      push;
    logic                      pop;
    logic [LW-1:0]             level_reg, level_next;
    logic [LW-1:0]             level_dec;
    dbgu_pkg::status_t         error_reg, error_now;
    dbgu_pkg::class_t          here;

    logic                      busy_reg;
    logic                      s1_pop_reg;
    logic                      s1_last_reg;
    dbgu_pkg::class_t          s1_here_reg;
    dbgu_pkg::status_t         s1_err_reg;

    logic [1:0]                ram_rdata;
    dbgu_pkg::class_t          partner;
    logic                      gu_hit;
    logic [11:0]               gu_count_reg, gu_count_next;
    logic [11:0]               pair_count_reg, pair_count_next;

    logic [11:0]               hold_gu_reg;
    logic [11:0]               hold_pairs_reg;
    dbgu_pkg::status_t         hold_status_reg;

    dbgu_pkg::div_req_t        div_req;
    logic                      div_done;
    logic [14:0]               div_quot;
    logic                      move;

    logic                      out_valid_reg;
    logic [14:0]               gu_percent_reg;
    logic [11:0]               gu_pairs_reg;
    logic [11:0]               all_pairs_reg;
    logic [1:0]                status_reg;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;
    assign is_open  = (struct_char == dbgu_pkg::CHAR_OPEN);
    assign is_close = (struct_char == dbgu_pkg::CHAR_CLOSE);
    assign push     = accept && is_open && (level_reg != LEVEL_FULL);
    assign pop      = accept && is_close && (level_reg != '0);
    assign here     = dbgu_pkg::base_class(seq_char);
    assign level_dec = level_reg - 1'b1;

    // keep the first error of the sequence
    always_comb
    begin
        error_now = error_reg;
        if (error_reg == dbgu_pkg::ST_OK)
        begin
            if (is_open && level_reg == LEVEL_FULL)
            begin
                error_now = dbgu_pkg::ST_OVERFLOW;
            end
            else if (is_close && level_reg == '0)
            begin
                error_now = dbgu_pkg::ST_UNMATCHED;
            end
        end
    end

    always_comb
    begin
        level_next = level_reg;
        if (accept && last)
        begin
            level_next = '0;
        end
        else if (push)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop)
        begin
            level_next = level_dec;
        end
    end

    dbgu_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .en    (push || pop),
        .we    (push),
        .addr  (push ? level_reg[AW-1:0] : level_dec[AW-1:0]),
        .wdata (here),
        .rdata (ram_rdata)
    );

    assign partner = dbgu_pkg::class_t'(ram_rdata);
    assign gu_hit  = s1_pop_reg &&
                     ((partner == dbgu_pkg::CLS_G && s1_here_reg == dbgu_pkg::CLS_UT) ||
                      (partner == dbgu_pkg::CLS_UT && s1_here_reg == dbgu_pkg::CLS_G));

    always_comb
    begin
        pair_count_next = pair_count_reg;
        gu_count_next   = gu_count_reg;
        if (s1_pop_reg && pair_count_reg != dbgu_pkg::COUNT_MAX)
        begin
            pair_count_next = pair_count_reg + 1'b1;
        end
        if (gu_hit && gu_count_reg != dbgu_pkg::COUNT_MAX)
        begin
            gu_count_next = gu_count_reg + 1'b1;
        end
    end

    assign div_req.start = s1_last_reg;
    assign div_req.gu    = gu_count_next;
    assign div_req.pairs = pair_count_next;

    dbgu_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .ack      (move),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign move = div_done && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg      <= '0;
            error_reg      <= dbgu_pkg::ST_OK;
            busy_reg       <= 1'b0;
            s1_pop_reg     <= 1'b0;
            s1_last_reg    <= 1'b0;
            gu_count_reg   <= '0;
            pair_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            level_reg   <= level_next;
            s1_pop_reg  <= pop;
            s1_last_reg <= accept && last;
            if (accept)
            begin
                error_reg <= last ? dbgu_pkg::ST_OK : error_now;
            end
            if (accept && last)
            begin
                busy_reg <= 1'b1;
            end
            else if (move)
            begin
                busy_reg <= 1'b0;
            end
            if (s1_last_reg)
            begin
                gu_count_reg   <= '0;
                pair_count_reg <= '0;
            end
            else
            begin
                gu_count_reg   <= gu_count_next;
                pair_count_reg <= pair_count_next;
            end
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_here_reg <= here;
            s1_err_reg  <= error_now;
        end
        if (s1_last_reg)
        begin
            hold_gu_reg     <= gu_count_next;
            hold_pairs_reg  <= pair_count_next;
            hold_status_reg <= s1_err_reg;
        end
        if (move)
        begin
            gu_percent_reg <= div_quot;
            gu_pairs_reg   <= hold_gu_reg;
            all_pairs_reg  <= hold_pairs_reg;
            status_reg     <= hold_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign gu_percent = gu_percent_reg;
    assign gu_pairs   = gu_pairs_reg;
    assign all_pairs  = all_pairs_reg;
    assign status     = status_reg;

`ifndef SYNTH
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_FULL)
        else $error("stack level beyond depth");

    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> !in_ready)
        else $error("input taken while a result is being formed");

    a_pairs_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gu_pairs <= all_pairs))
        else $error("gu pairs exceed all pairs");

    a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gu_percent <= dbgu_pkg::PERCENT_SCALE))
        else $error("gu percent out of range");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        s1_last_reg |-> (busy_reg && !div_done))
        else $error("divider started while still holding a result");
`endif

endmodule

>>> tb/dot_bracket_gu_pair_counter_test.sv
`timescale 1ns / 100ps

module dot_bracket_gu_pair_counter_test;

    localparam int DEPTH           = dbgu_pkg::DEF_STACK_DEPTH;
    localparam int RANDOM_BRACKETS = 850;
    localparam int HOLD_CYCLES     = 500;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 3000000;
    localparam int REPORT_MAX      = 20;

    localparam logic [7:0]  CH_A     = "A";
    localparam logic [7:0]  CH_C     = "C";
    localparam logic [7:0]  CH_DOT   = ".";
    localparam logic [7:0]  CH_SQ    = "[";
    localparam logic [7:0]  CH_OPEN  = dbgu_pkg::CHAR_OPEN;
    localparam logic [7:0]  CH_CLOSE = dbgu_pkg::CHAR_CLOSE;
    localparam logic [7:0]  CH_G     = dbgu_pkg::CHAR_G_UC;
    localparam logic [7:0]  CH_GL    = dbgu_pkg::CHAR_G_LC;
    localparam logic [7:0]  CH_U     = dbgu_pkg::CHAR_U_UC;
    localparam logic [7:0]  CH_UL    = dbgu_pkg::CHAR_U_LC;
    localparam logic [7:0]  CH_T     = dbgu_pkg::CHAR_T_UC;
    localparam logic [7:0]  CH_TL    = dbgu_pkg::CHAR_T_LC;
    localparam logic [95:0] BASE_MIX = "GgUuTtGgAaCc";

    localparam dbgu_pkg::status_t STAT_OK  = dbgu_pkg::ST_OK;
    localparam dbgu_pkg::status_t STAT_UNM = dbgu_pkg::ST_UNMATCHED;
    localparam dbgu_pkg::status_t STAT_OVF = dbgu_pkg::ST_OVERFLOW;

    typedef struct packed {
        logic [14:0]       pct;
        logic [11:0]       gu;
        logic [11:0]       pairs;
        dbgu_pkg::status_t status;
    } gu_tally_t;

    typedef struct packed {
        logic [7:0]  base;
        logic [7:0]  mark;
        logic [12:0] reps;
        logic        ends;
        logic        typed;
        gu_tally_t   want;
    } plan_row_t;

    localparam gu_tally_t NO_TALLY = '0;

    // Each row repeats one position; ends marks the final repeat as last.
    localparam plan_row_t PLAN [27] = '{
        '{CH_A,  CH_DOT,   13'd1,    1'b1, 1'b1, '{15'd0, 12'd0, 12'd0, STAT_OK}},
        '{CH_G,  CH_OPEN,  13'd1,    1'b0, 1'b0, NO_TALLY},
        '{CH_U,  CH_CLOSE, 13'd1,    1'b1, 1'b1, '{15'd25600, 12'd1, 12'd1, STAT_OK}},
        '{CH_GL, CH_OPEN,  13'd1,    1'b0, 1'b0, NO_TALLY},
        '{CH_A,  CH_OPEN,  13'd1,    1'b0, 1'b0, NO_TALLY},
        '{CH_T,  CH_CLOSE, 13'd1,    1'b0, 1'b0, NO_TALLY},
        '{8'h00, 8'hFF,    13'd1,    1'b0, 1'b0, NO_TALLY},
        '{8'hFF, 8'h00,    13'd1,    1'b0, 1'b0, NO_TALLY},
        '{CH_UL, CH_CLOSE, 13'd1,    1'b1, 1'b0, NO_TALLY},
        '{CH_C,  CH_OPEN,  13'd1,    1'b0, 1'b0, NO_TALLY},
        '{CH_G,  CH_CLOSE, 13'd1,    1'b1, 1'b1, '{15'd0, 12'd0, 12'd1, STAT_OK}},
        '{CH_TL, CH_OPEN,  13'd1,    1'b0, 1'b0, NO_TALLY},
        '{CH_G,  CH_SQ,    13'd1,    1'b0, 1'b0, NO_TALLY},
        '{CH_GL, CH_CLOSE, 13'd1,    1'b0, 1'b0, NO_TALLY},
        '{CH_U,  CH_OPEN,  13'd1,    1'b0, 1'b0, NO_TALLY},
        '{CH_T,  CH_CLOSE, 13'd1,    1'b1, 1'b0, NO_TALLY},
        '{CH_G,  CH_CLOSE, 13'd1,    1'b1, 1'b1, '{15'd0, 12'd0, 12'd0, STAT_UNM}},
        '{CH_G,  CH_OPEN,  13'd2049, 1'b0, 1'b0, NO_TALLY},
        '{CH_U,  CH_CLOSE, 13'd1,    1'b1, 1'b1, '{15'd25600, 12'd1, 12'd1, STAT_OVF}},
        '{CH_C,  CH_CLOSE, 13'd1,    1'b0, 1'b0, NO_TALLY},
        '{CH_A,  CH_OPEN,  13'd2049, 1'b1, 1'b1, '{15'd0, 12'd0, 12'd0, STAT_UNM}},
        '{CH_G,  CH_OPEN,  13'd2048, 1'b0, 1'b0, NO_TALLY},
        '{CH_U,  CH_CLOSE, 13'd2048, 1'b0, 1'b0, NO_TALLY},
        '{CH_GL, CH_OPEN,  13'd2048, 1'b0, 1'b0, NO_TALLY},
        '{CH_TL, CH_CLOSE, 13'd2048, 1'b1, 1'b1, '{15'd25600, 12'd4095, 12'd4095, STAT_OK}},
        '{CH_G,  CH_OPEN,  13'd1,    1'b1, 1'b1, '{15'd0, 12'd0, 12'd0, STAT_OK}},
        '{CH_U,  CH_CLOSE, 13'd1,    1'b1, 1'b1, '{15'd0, 12'd0, 12'd0, STAT_UNM}}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  seq_char;
    logic [7:0]  struct_char;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [14:0] gu_percent;
    logic [11:0] gu_pairs;
    logic [11:0] all_pairs;
    logic [1:0]  status;

    // Predictor state
    dbgu_pkg::class_t  base_stack [DEPTH];
    int unsigned       stack_level;
    logic [11:0]       gu_run;
    logic [11:0]       pair_run;
    dbgu_pkg::status_t err_run;

    gu_tally_t   expected_tallies [$];
    gu_tally_t   head;

    bit quiet;
    bit squeeze_pending;
    int fails;
    int chars_sent;
    int random_brackets;
    int tallies_seen;
    int in_stall_cycles;
    int cycle_count;

    dot_bracket_gu_pair_counter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .seq_char    (seq_char),
        .struct_char (struct_char),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .gu_percent  (gu_percent),
        .gu_pairs    (gu_pairs),
        .all_pairs   (all_pairs),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic dbgu_pkg::class_t classify(input logic [7:0] c);
        case (c)
            CH_G, CH_GL:              return dbgu_pkg::CLS_G;
            CH_U, CH_UL, CH_T, CH_TL: return dbgu_pkg::CLS_UT;
            default:                  return dbgu_pkg::CLS_OTHER;
        endcase
    endfunction

    // Advance the pairing state by one position; return 1 with the tally on last.
    function automatic bit tally_step(input logic [7:0] base, input logic [7:0] mark,
                                      input logic lst, output gu_tally_t res);
        dbgu_pkg::class_t here;
        dbgu_pkg::class_t partner;
        int unsigned      share;
        here  = classify(base);
        res   = '0;
        share = 0;
        if (mark == CH_OPEN)
        begin
            if (stack_level < DEPTH)
            begin
                base_stack[stack_level] = here;
                stack_level++;
            end
            else if (err_run == STAT_OK)
                err_run = STAT_OVF;
        end
        else if (mark == CH_CLOSE)
        begin
            if (stack_level == 0)
            begin
                if (err_run == STAT_OK)
                    err_run = STAT_UNM;
            end
            else
            begin
                stack_level--;
                partner = base_stack[stack_level];
                if (pair_run != dbgu_pkg::COUNT_MAX)
                    pair_run++;
                if ((partner == dbgu_pkg::CLS_G && here == dbgu_pkg::CLS_UT) ||
                    (partner == dbgu_pkg::CLS_UT && here == dbgu_pkg::CLS_G))
                    if (gu_run != dbgu_pkg::COUNT_MAX)
                        gu_run++;
            end
        end
        if (!lst)
            return 1'b0;
        if (pair_run != 0)
            share = (32'(gu_run) * 32'(dbgu_pkg::PERCENT_SCALE)) / 32'(pair_run);
        res.pct    = share[14:0];
        res.gu     = gu_run;
        res.pairs  = pair_run;
        res.status = err_run;
        stack_level = 0;
        gu_run      = '0;
        pair_run    = '0;
        err_run     = STAT_OK;
        return 1'b1;
    endfunction

    task automatic send_char(input logic [7:0] base, input logic [7:0] mark, input logic lst,
                             input logic typed, input gu_tally_t want);
        gu_tally_t got;
        while (!quiet && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        seq_char    <= base;
        struct_char <= mark;
        last        <= lst;
        do @(posedge clk); while (!in_ready);
        chars_sent++;
        if (tally_step(base, mark, lst, got))
            expected_tallies.push_back(typed ? want : got);
    endtask

    function automatic logic [7:0] pick_base();
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));
        return BASE_MIX[8 * $urandom_range(11) +: 8];
    endfunction

    // Mostly balanced structures; some with bracket noise, some with garbage marks.
    task automatic send_random_sequence();
        int         len;
        int         open_cnt;
        int         kind;
        int         remaining;
        int         pick;
        logic [7:0] base;
        logic [7:0] mark;
        logic       lst;
        kind     = $urandom_range(9);
        len      = ($urandom_range(15) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
        open_cnt = 0;
        for (int i = 0; i < len; i++)
        begin
            remaining = len - i;
            base      = pick_base();
            pick      = $urandom_range(9);
            if (kind == 0 || $urandom_range(49) == 0)
                mark = 8'($urandom_range(255));
            else if (kind == 1)
                mark = (pick < 4) ? CH_OPEN : (pick < 8) ? CH_CLOSE : CH_DOT;
            else if (open_cnt >= remaining)
                mark = CH_CLOSE;
            else if (pick < 4 && open_cnt + 2 <= remaining)
                mark = CH_OPEN;
            else if (pick < 8 && open_cnt > 0)
                mark = CH_CLOSE;
            else
                mark = CH_DOT;
            if (mark == CH_OPEN)
                open_cnt++;
            else if (mark == CH_CLOSE && open_cnt > 0)
                open_cnt--;
            lst = (i == len - 1);
            if (mark == CH_OPEN || mark == CH_CLOSE || lst)
                random_brackets++;
            send_char(base, mark, lst, 1'b0, NO_TALLY);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act)
        begin
            fails++;
            if (fails <= REPORT_MAX)
                $display("%0t: %s expected %0d, got %0d", $time, name, exp, act);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_ready)
            in_stall_cycles++;
        if (rst_n && out_valid && out_ready)
        begin
            tallies_seen++;
            if (expected_tallies.size() == 0)
            begin
                fails++;
                if (fails <= REPORT_MAX)
                    $display("%0t: result with none expected, got pct %0d gu %0d pairs %0d st %0d",
                             $time, gu_percent, gu_pairs, all_pairs, status);
            end
            else
            begin
                head = expected_tallies.pop_front();
                check_field("gu_percent", 32'(head.pct), 32'(gu_percent));
                check_field("gu_pairs", 32'(head.gu), 32'(gu_pairs));
                check_field("all_pairs", 32'(head.pairs), 32'(all_pairs));
                check_field("status", 32'(head.status), 32'(status));
            end
        end
    end

    // Receiver: random stalls, one long hold-off to back up the block.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (squeeze_pending)
            begin
                squeeze_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= quiet || ($urandom_range(99) >= 25);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     expected_tallies.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        plan_row_t row;
        in_valid    <= 1'b0;
        seq_char    <= '0;
        struct_char <= '0;
        last        <= 1'b0;
        rst_n       <= 1'b0;
        stack_level = 0;
        gu_run      = '0;
        pair_run    = '0;
        err_run     = STAT_OK;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[r])
        begin
            row = PLAN[r];
            for (int k = 0; k < row.reps; k++)
                send_char(row.base, row.mark, row.ends && (k == row.reps - 1), row.typed, row.want);
        end

        squeeze_pending = 1'b1;
        while (random_brackets < RANDOM_BRACKETS)
        begin
            // hold a stretch with no idling on either side
            quiet = (random_brackets >= 300 && random_brackets < 450);
            send_random_sequence();
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        while (expected_tallies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Streamed %0d positions (%0d random bracket or end marks), scored %0d sequences,",
                 chars_sent, random_brackets, tallies_seen);
        $display("including overflow, unmatched close, count saturation and %0d input stall cycles.",
                 in_stall_cycles);
        if (fails == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
